FILE: hw/rtl/rws_pkg.sv
// rws_pkg: shared constants, controller state type and the command/status
// structs of the roulette wheel selector
// no dependencies
package rws_pkg;

	localparam int SLOTS_DEFAULT = 16;
	localparam int WEIGHT_W      = 10;
	localparam int FIT_W         = 11;
	localparam int DRAW_W        = 16;
	localparam int SLOT_FIELD_W  = 4;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR,
		ST_DR_MUL,
		ST_DR_WALK,
		ST_DR_DRAIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic load_read;
		logic load_write;
		logic draw_start;
		logic walk_read;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

FILE: hw/rtl/rws_if.sv
// rws_req_if and rws_res_if: valid/ready channels of the roulette wheel selector
// depends on rws_pkg for field widths
interface rws_req_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    kind;
	logic [rws_pkg::SLOT_FIELD_W-1:0]        slot;
	logic signed [rws_pkg::FIT_W-1:0]        fitness;
	logic [rws_pkg::DRAW_W-1:0]              draw_value;

	modport source(output valid, kind, slot, fitness, draw_value, input ready);
	modport sink(input valid, kind, slot, fitness, draw_value, output ready);
endinterface

interface rws_res_if;
	logic                             valid;
	logic                             ready;
	logic [rws_pkg::SLOT_FIELD_W-1:0] selected_slot;
	logic                             no_weight;

	modport source(output valid, selected_slot, no_weight, input ready);
	modport sink(input valid, selected_slot, no_weight, output ready);
endinterface

FILE: hw/rtl/rws_ctrl.sv
// rws_ctrl: sequencer for load and draw requests
// depends on rws_pkg (state_t, cmd_t, sts_t, kind codes)
module rws_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_kind,
	output logic           req_ready,
	output rws_pkg::cmd_t  cmd,
	input  rws_pkg::sts_t  sts
);

	rws_pkg::state_t state_q;
	rws_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rws_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			rws_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = (req_kind == rws_pkg::KIND_DRAW) ? rws_pkg::ST_DR_MUL
					                                          : rws_pkg::ST_LD_RD;
				end
			end
			rws_pkg::ST_LD_RD: begin
				cmd.load_read = 1'b1;
				state_d = rws_pkg::ST_LD_WR;
			end
			rws_pkg::ST_LD_WR: begin
				cmd.load_write = 1'b1;
				state_d = rws_pkg::ST_IDLE;
			end
			rws_pkg::ST_DR_MUL: begin
				cmd.draw_start = 1'b1;
				state_d = rws_pkg::ST_DR_WALK;
			end
			rws_pkg::ST_DR_WALK: begin
				cmd.walk_read = 1'b1;
				if (sts.walk_last) begin
					state_d = rws_pkg::ST_DR_DRAIN;
				end
			end
			rws_pkg::ST_DR_DRAIN: begin
				// last compare done and output register can take the result
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.result_load = 1'b1;
					state_d = rws_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rws_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/rws_datapath.sv
// rws_datapath: weight memory, running total, draw walk pipeline and result register
// depends on rws_pkg (widths, cmd_t, sts_t)
module rws_datapath #(
	parameter int SLOTS = rws_pkg::SLOTS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rws_pkg::cmd_t                       cmd,
	output rws_pkg::sts_t                       sts,
	input  logic [rws_pkg::SLOT_FIELD_W-1:0]    in_slot,
	input  logic signed [rws_pkg::FIT_W-1:0]    in_fitness,
	input  logic [rws_pkg::DRAW_W-1:0]          in_draw_value,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [rws_pkg::SLOT_FIELD_W-1:0]    res_slot,
	output logic                                res_flag
);

	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TOTAL_W = rws_pkg::WEIGHT_W + SLOT_W;
	localparam int LHS_W   = rws_pkg::DRAW_W + TOTAL_W;
	localparam int TOTAL_MAX = SLOTS * ((1 << rws_pkg::WEIGHT_W) - 1);

	// captured request
	logic [rws_pkg::SLOT_FIELD_W-1:0] slot_q;
	logic [rws_pkg::WEIGHT_W-1:0]     w_q;
	logic [rws_pkg::DRAW_W-1:0]       r_q;

	logic [rws_pkg::WEIGHT_W-1:0] mem [SLOTS];
	logic [rws_pkg::WEIGHT_W-1:0] rdata_q;
	logic [SLOTS-1:0]             vld_q;
	logic                         vld_rd_q;

	logic [TOTAL_W-1:0] total_q;
	logic [LHS_W-1:0]   lhs_q;
	logic [TOTAL_W-1:0] prefix_q;
	logic [SLOT_W-1:0]  cnt_q;
	logic               rd_s1;
	logic               cmp_s2;
	logic [SLOT_W-1:0]  idx_s1;
	logic [SLOT_W-1:0]  idx_s2;
	logic               found_q;
	logic [SLOT_W-1:0]  chosen_q;

	logic                              out_valid_q;
	logic [rws_pkg::SLOT_FIELD_W-1:0]  out_slot_q;
	logic                              out_flag_q;

	logic                         slot_ok;
	logic [SLOT_W-1:0]            slot_addr;
	logic [SLOT_W-1:0]            raddr;
	logic [rws_pkg::WEIGHT_W-1:0] w_rd;
	logic [rws_pkg::WEIGHT_W-1:0] w_clamped;
	logic [LHS_W-1:0]             scaled;
	logic                         total_zero;
	logic                         hit;

	// negative fitness clamps to zero; positive values already fit in the weight
	assign w_clamped = in_fitness[rws_pkg::FIT_W-1] ? '0 : in_fitness[rws_pkg::WEIGHT_W-1:0];

	assign slot_ok    = int'(slot_q) < SLOTS;
	assign slot_addr  = SLOT_W'(slot_q);
	assign raddr      = cmd.walk_read ? cnt_q : slot_addr;
	assign w_rd       = vld_rd_q ? rdata_q : '0;
	// prefix * 65535 as shift and subtract
	assign scaled     = {prefix_q, {rws_pkg::DRAW_W{1'b0}}} - LHS_W'(prefix_q);
	assign total_zero = (total_q == '0);
	assign hit        = cmp_s2 && !found_q && (lhs_q <= scaled);

	// weight memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.load_write && slot_ok) begin
			mem[slot_addr] <= w_q;
		end
		rdata_q <= mem[raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q <= in_slot;
			w_q    <= w_clamped;
			r_q    <= in_draw_value;
		end
		if (cmd.draw_start) begin
			lhs_q <= LHS_W'(r_q * total_q);
		end
		if (cmd.walk_read) begin
			idx_s1 <= cnt_q;
		end
		idx_s2 <= idx_s1;
		if (cmd.result_load) begin
			out_slot_q <= total_zero ? '0 : rws_pkg::SLOT_FIELD_W'(chosen_q);
			out_flag_q <= total_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			vld_rd_q    <= 1'b0;
			total_q     <= '0;
			prefix_q    <= '0;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			cmp_s2      <= 1'b0;
			found_q     <= 1'b0;
			chosen_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_rd_q <= vld_q[raddr];
			rd_s1    <= cmd.walk_read;
			cmp_s2   <= rd_s1;
			if (cmd.load_write && slot_ok) begin
				vld_q[slot_addr] <= 1'b1;
				total_q <= total_q - TOTAL_W'(w_rd) + TOTAL_W'(w_q);
			end
			if (cmd.draw_start) begin
				prefix_q <= '0;
				cnt_q    <= '0;
				found_q  <= 1'b0;
				chosen_q <= SLOT_W'(SLOTS - 1);
			end else begin
				if (cmd.walk_read) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (rd_s1) begin
					prefix_q <= prefix_q + TOTAL_W'(w_rd);
				end
				if (hit) begin
					found_q  <= 1'b1;
					chosen_q <= idx_s2;
				end
			end
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.walk_last = (cnt_q == SLOT_W'(SLOTS - 1));
	assign sts.pipe_busy = rd_s1 || cmp_s2;
	assign sts.out_free  = !out_valid_q || res_ready;

	assign res_valid = out_valid_q;
	assign res_slot  = out_slot_q;
	assign res_flag  = out_flag_q;

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_write |-> $past(cmd.load_read))
		else $error("weight write without preceding read of the old weight");

	a_result_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> (!rd_s1 && !cmp_s2))
		else $error("result loaded while walk compares still in flight");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(total_q) <= TOTAL_MAX)
		else $error("running total exceeds the largest possible weight sum");

	a_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && !cmd.draw_start) |=> found_q)
		else $error("selection lost during a walk");

endmodule

FILE: hw/rtl/roulette_wheel_selector.sv
// roulette_wheel_selector: fitness-proportionate selection over a store of weights
// depends on rws_pkg, rws_if (rws_req_if, rws_res_if), rws_ctrl, rws_datapath
//
// usage:
//   req channel carries kind, slot, fitness and draw_value. kind load writes the
//   clamped fitness of one slot (negatives become zero, slots >= SLOTS ignored) and
//   gives no result. kind draw returns one item on res: the first slot whose prefix
//   weight sum P meets draw_value*total <= P*65535, or slot 0 with no_weight set
//   when the total is zero.
//   a load occupies the block through capture, read of the old weight, and write of
//   weight and total.
//   a draw goes from accept through the multiply, then a walk over all SLOTS slots of
//   the single-port weight memory one read per cycle, then the add and compare pipeline
//   stages and the load of the result register.
//   one request is in work at a time; req.ready is high only between requests.
//   the result sits in an output register, so loads go on while it waits; if the
//   receiver stalls, a following draw holds at its end until the register frees up.
//   reset clears all weights (per-slot valid bits), the total and the output register.
module roulette_wheel_selector #(
	parameter int SLOTS = rws_pkg::SLOTS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	rws_req_if.sink   req,
	rws_res_if.source res
);

	rws_pkg::cmd_t cmd;
	rws_pkg::sts_t sts;

	rws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rws_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_slot       (req.slot),
		.in_fitness    (req.fitness),
		.in_draw_value (req.draw_value),
		.res_valid     (res.valid),
		.res_ready     (res.ready),
		.res_slot      (res.selected_slot),
		.res_flag      (res.no_weight)
	);

endmodule
